FILE: src/utf8_to_utf16_decoder_macros.svh
// Assertion macros shared by the UTF-8 to UTF-16 decoder modules.
`ifndef UTF8_TO_UTF16_DECODER_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define U2U_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define U2U_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/u2u_pkg.sv
// Shared types and constants of the UTF-8 to UTF-16 decoder.
`default_nettype none
package u2u_pkg;

   localparam int BYTE_W    = 8;
   localparam int VALUE_W   = 21;
   localparam int UNIT_W    = 16;
   localparam int REM_W     = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0]  ASCII_LIMIT = 8'h80;
   localparam logic [2:0]         LEAD2_TAG   = 3'b110;
   localparam logic [3:0]         LEAD3_TAG   = 4'b1110;
   localparam logic [4:0]         LEAD4_TAG   = 5'b11110;

   localparam logic [VALUE_W-1:0] BMP_MAX     = 21'h00FFFF;
   localparam logic [UNIT_W-1:0]  HIGH_OFFSET = 16'hD7C0;
   localparam logic [UNIT_W-1:0]  LOW_OFFSET  = 16'hDC00;

   // One finished code point travelling from front to back.
   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
   } u2u_entry_type;

endpackage
`default_nettype wire

FILE: src/u2u_front.sv
// Front end: accepts bytes, tracks open sequences, pushes finished code points.
`default_nettype none
module u2u_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [u2u_pkg::BYTE_W-1:0]   req_in_byte,
   input  wire                          queue_full,
   output u2u_pkg::u2u_entry_type       push
);
   import u2u_pkg::*;

   logic [REM_W-1:0]   rem_ff,   rem_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      rem_in     = rem_ff;
      value_in   = value_ff;
      push.valid = 1'b0;
      push.value = {{(VALUE_W-BYTE_W){1'b0}}, req_in_byte};
      if (accept) begin
         if (rem_ff != '0) begin
            // continuation: prefix bits are ignored
            value_in   = {value_ff[VALUE_W-7:0], req_in_byte[5:0]};
            rem_in     = rem_ff - 1'b1;
            push.value = value_in;
            push.valid = (rem_ff == REM_W'(1));
         end else if (req_in_byte < ASCII_LIMIT) begin
            push.valid = 1'b1;
         end else if (req_in_byte[7:5] == LEAD2_TAG) begin
            value_in = {{(VALUE_W-5){1'b0}}, req_in_byte[4:0]};
            rem_in   = REM_W'(1);
         end else if (req_in_byte[7:4] == LEAD3_TAG) begin
            value_in = {{(VALUE_W-4){1'b0}}, req_in_byte[3:0]};
            rem_in   = REM_W'(2);
         end else if (req_in_byte[7:3] == LEAD4_TAG) begin
            value_in = {{(VALUE_W-3){1'b0}}, req_in_byte[2:0]};
            rem_in   = REM_W'(3);
         end else begin
            // stray continuation or invalid lead passes through
            push.valid = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff   <= '0;
         value_ff <= '0;
      end else begin
         rem_ff   <= rem_in;
         value_ff <= value_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/u2u_queue.sv
// Short register queue of finished code points between front and back.
`default_nettype none
module u2u_queue (
   input  wire                          clock,
   input  wire                          reset,
   input  u2u_pkg::u2u_entry_type       push,
   output logic                         full,
   output u2u_pkg::u2u_entry_type       head,
   input  wire                          pop_ack
);
   import u2u_pkg::*;

`include "utf8_to_utf16_decoder_macros.svh"

   logic [VALUE_W-1:0]     slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff,  count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.value = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop_ack && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= push.value;
   end

   `U2U_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue overfilled")
   `U2U_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1, "push lost")
   `U2U_ASSERT_NOW(a_ptr_gap, 1'b1, full || (QUEUE_PTR_W'(count_ff) == QUEUE_PTR_W'(wr_ptr_ff - rd_ptr_ff)), "pointer mismatch")

endmodule
`default_nettype wire

FILE: src/u2u_back.sv
// Back end: turns code points into one unit or a surrogate pair on the output.
`default_nettype none
module u2u_back (
   input  wire                          clock,
   input  wire                          reset,
   input  u2u_pkg::u2u_entry_type       head,
   output logic                         pop_ack,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [u2u_pkg::UNIT_W-1:0]   rsp_code_unit,
   output logic                         rsp_last_of_run
);
   import u2u_pkg::*;

`include "utf8_to_utf16_decoder_macros.svh"

   logic              valid_ff, valid_in;
   logic [UNIT_W-1:0] unit_ff,  unit_in;
   logic              last_ff,  last_in;
   logic              pend_ff,  pend_in;
   logic [UNIT_W-1:0] low_ff,   low_in;
   logic              slot_free;
   logic              is_pair;
   logic [UNIT_W-1:0] high_unit, low_unit;

   assign slot_free = !valid_ff || rsp_ready;
   assign is_pair   = (head.value > BMP_MAX);
   assign high_unit = {{(UNIT_W-(VALUE_W-10)){1'b0}}, head.value[VALUE_W-1:10]} + HIGH_OFFSET;
   assign low_unit  = {{(UNIT_W-10){1'b0}}, head.value[9:0]} + LOW_OFFSET;

   always_comb begin
      valid_in = valid_ff;
      unit_in  = unit_ff;
      last_in  = last_ff;
      pend_in  = pend_ff;
      low_in   = low_ff;
      pop_ack  = 1'b0;
      if (slot_free) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            unit_in  = low_ff;
            last_in  = 1'b1;
            pend_in  = 1'b0;
         end else if (head.valid) begin
            pop_ack  = 1'b1;
            valid_in = 1'b1;
            unit_in  = is_pair ? high_unit : head.value[UNIT_W-1:0];
            last_in  = !is_pair;
            pend_in  = is_pair;
            low_in   = low_unit;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff <= unit_in;
      last_ff <= last_in;
      low_ff  <= low_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_code_unit   = unit_ff;
   assign rsp_last_of_run = last_ff;

   `U2U_ASSERT_NOW(a_pend_high_out, pend_ff, valid_ff && !last_ff, "low half without high half")
   `U2U_ASSERT_NEXT(a_low_follows, valid_ff && rsp_ready && pend_ff, valid_ff && last_ff && !pend_ff, "low half missing")
   `U2U_ASSERT_NOW(a_no_pop_pending, pend_ff, !pop_ack, "popped during pair")

endmodule
`default_nettype wire

FILE: src/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 decoder.
//
// Usage:
//   req_*  : one UTF-8 byte per transfer on req_in_byte (valid/ready).
//   rsp_*  : one UTF-16 code unit per transfer on rsp_code_unit, with
//            rsp_last_of_run high on the last unit a byte produces.
//   Lead and middle bytes of a sequence produce no transfer; the byte that
//   ends a sequence, an ASCII byte or a stray byte produces one unit, or a
//   surrogate pair (high half first) for values above 0xFFFF.
// Path: a finishing byte's code point is written into the queue at its
//   transfer; its first unit is loaded into the single output register of
//   the back end once that register is free and the entry heads the queue.
// Throughput: one byte per cycle in unless the queue is full; a four-byte
//   sequence still keeps the input at one byte per cycle. One unit per cycle
//   out while rsp_ready is high; a pair goes out as two units.
// Stalls: a 4-entry queue of finished code points separates the byte
//   front end from the output back end; req_ready drops only when it is full.
// Reset: synchronous, active high; closes any open sequence and empties
//   the queue and the output register.
`default_nettype none
module utf8_to_utf16_decoder (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire  [u2u_pkg::BYTE_W-1:0]   req_in_byte,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic [u2u_pkg::UNIT_W-1:0]   rsp_code_unit,
   output logic                         rsp_last_of_run
);
   import u2u_pkg::*;

   u2u_entry_type push;   // finished code point from the front end
   u2u_entry_type head;   // oldest queued code point
   logic          queue_full;
   logic          pop_ack;

   // byte classification and sequence accumulation
   u2u_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .queue_full  (queue_full),
      .push        (push)
   );

   // decoupling queue
   u2u_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (queue_full),
      .head    (head),
      .pop_ack (pop_ack)
   );

   // unit / surrogate pair generation and output register
   u2u_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .pop_ack         (pop_ack),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the UTF-8 to UTF-16 decoder: directed table, then random stream.
module tb_top;
   import u2u_pkg::*;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 12;
   localparam int RANDOM_ITEMS   = 425;
   localparam int DRAIN_CYCLES   = 10;   // quiet margin before ending the run
   localparam int WATCHDOG_LIMIT = 1000; // cycles without any transfer
   localparam int REPORT_LIMIT   = 10;

   // Predictor constants.
   localparam logic [VALUE_W-1:0] BMP_TOP   = 21'h00FFFF;
   localparam logic [UNIT_W-1:0]  HIGH_BIAS = 16'hD7C0;
   localparam logic [UNIT_W-1:0]  LOW_BIAS  = 16'hDC00;

   // Shape of one random chunk of the byte stream.
   typedef enum int {SEQ_ASCII, SEQ_TWO, SEQ_THREE, SEQ_FOUR, SEQ_NOISE} seq_kind_type;

   typedef struct packed {
      logic [UNIT_W-1:0] unit;
      logic              last;
   } utf16_unit_type;

   // One stimulus byte; typed rows carry their expected units, others use the predictor.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              typed;
      logic [1:0]        n_units;
      utf16_unit_type    first;
      utf16_unit_type    second;
   } byte_row_type;

   localparam utf16_unit_type NO_UNIT = '{16'h0000, 1'b0};

   localparam int DIR_ROWS = 25;
   localparam byte_row_type DIRECTED [DIR_ROWS] = '{
      // ASCII extremes
      '{8'h00, 1'b1, 2'd1, '{16'h0000, 1'b1}, NO_UNIT},
      '{8'h7F, 1'b1, 2'd1, '{16'h007F, 1'b1}, NO_UNIT},
      // stray continuation and illegal lead bytes pass through
      '{8'h80, 1'b1, 2'd1, '{16'h0080, 1'b1}, NO_UNIT},
      '{8'hF8, 1'b1, 2'd1, '{16'h00F8, 1'b1}, NO_UNIT},
      '{8'hFF, 1'b1, 2'd1, '{16'h00FF, 1'b1}, NO_UNIT},
      // lead byte alone gives nothing
      '{8'hC2, 1'b1, 2'd0, NO_UNIT, NO_UNIT},
      '{8'hA9, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      // largest 2-byte value
      '{8'hDF, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      '{8'hBF, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      // 3-byte, ordinary and top of the BMP
      '{8'hE2, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      '{8'h82, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      '{8'hAC, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      '{8'hEF, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      '{8'hBF, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      '{8'hBF, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      // 4-byte, surrogate pair
      '{8'hF0, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      '{8'h9F, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      '{8'h98, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      '{8'h80, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      // largest value the accumulator holds, far above 0x10FFFF
      '{8'hF7, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      '{8'hBF, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      '{8'hBF, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      '{8'hBF, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      // ASCII byte taken as continuation, prefix unchecked
      '{8'hC3, 1'b0, 2'd0, NO_UNIT, NO_UNIT},
      '{8'h41, 1'b0, 2'd0, NO_UNIT, NO_UNIT}
   };

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_in_byte     = '0;
   logic                rsp_valid;
   logic                rsp_ready       = 1'b0;
   logic [UNIT_W-1:0]   rsp_code_unit;
   logic                rsp_last_of_run;

   utf8_to_utf16_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Predictor: open-sequence count and accumulated code point.
   // ---------------------------------------------------------------------------------------
   logic [1:0]         seq_left = '0;
   logic [VALUE_W-1:0] code_acc = '0;
   utf16_unit_type     fresh_units[$];    // units caused by the byte just decoded
   utf16_unit_type     expected_units[$]; // units still owed by the DUT, oldest first

   task automatic emit_code_point(input logic [VALUE_W-1:0] cp);
      if (cp > BMP_TOP) begin
         // surrogate pair, high half first
         fresh_units.insert(fresh_units.size(),
                            utf16_unit_type'{16'(cp >> 10) + HIGH_BIAS, 1'b0});
         fresh_units.insert(fresh_units.size(),
                            utf16_unit_type'{{6'b0, cp[9:0]} + LOW_BIAS, 1'b1});
      end else begin
         fresh_units.insert(fresh_units.size(), utf16_unit_type'{cp[UNIT_W-1:0], 1'b1});
      end
   endtask

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      fresh_units.delete();
      if (seq_left != 2'd0) begin
         // any byte continues an open sequence, only its low six bits count
         code_acc = {code_acc[VALUE_W-7:0], b[5:0]};
         seq_left = seq_left - 2'd1;
         if (seq_left == 2'd0) emit_code_point(code_acc);
      end else if (!b[7]) begin
         emit_code_point({13'b0, b});
      end else if (b[7:5] == 3'b110) begin
         code_acc = {16'b0, b[4:0]};
         seq_left = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         code_acc = {17'b0, b[3:0]};
         seq_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
         code_acc = {18'b0, b[2:0]};
         seq_left = 2'd3;
      end else begin
         // stray continuation or 0xF8..0xFF
         emit_code_point({13'b0, b});
      end
   endtask

   // Predict always, so state tracks; typed rows substitute their own expectation.
   task automatic accept_row(input byte_row_type row);
      decode_byte(row.data);
      if (row.typed) begin
         if (row.n_units >= 2'd1) expected_units.insert(expected_units.size(), row.first);
         if (row.n_units >= 2'd2) expected_units.insert(expected_units.size(), row.second);
      end else begin
         foreach (fresh_units[i]) expected_units.insert(expected_units.size(), fresh_units[i]);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------------------
   int fail_count = 0;

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   task automatic check_unit(input logic [UNIT_W-1:0] unit, input logic last);
      utf16_unit_type want;
      if (expected_units.size() == 0) begin
         note_failure($sformatf("unexpected unit %h last %b", unit, last));
      end else begin
         want = expected_units.pop_front();
         if (unit !== want.unit)
            note_failure($sformatf("code_unit: expected %h, got %h", want.unit, unit));
         if (last !== want.last)
            note_failure($sformatf("last_of_run: expected %b, got %b (unit %h)",
                                   want.last, last, want.unit));
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus build: directed table, then random sequences with some noise.
   // ---------------------------------------------------------------------------------------
   byte_row_type stim_q[$];

   task automatic add_byte(input logic [BYTE_W-1:0] b);
      stim_q.insert(stim_q.size(), byte_row_type'{b, 1'b0, 2'd0, NO_UNIT, NO_UNIT});
   endtask

   // Mostly proper 10xxxxxx, sometimes an arbitrary byte to break the prefix.
   function automatic logic [BYTE_W-1:0] cont_byte();
      if ($urandom_range(0, 9) == 0) return 8'($urandom);
      return {2'b10, 6'($urandom)};
   endfunction

   task automatic build_random_stream();
      seq_kind_type kind;
      int           pick;
      while (stim_q.size() < DIR_ROWS + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         kind = (pick < 25) ? SEQ_ASCII :
                (pick < 40) ? SEQ_TWO   :
                (pick < 55) ? SEQ_THREE :
                (pick < 82) ? SEQ_FOUR  : SEQ_NOISE;
         case (kind)
            SEQ_ASCII: begin
               add_byte({1'b0, 7'($urandom)});
            end
            SEQ_TWO: begin
               add_byte({3'b110, 5'($urandom)});
               add_byte(cont_byte());
            end
            SEQ_THREE: begin
               add_byte({4'b1110, 4'($urandom)});
               repeat (2) add_byte(cont_byte());
            end
            SEQ_FOUR: begin
               add_byte({5'b11110, 3'($urandom)});
               repeat (3) add_byte(cont_byte());
            end
            default: begin
               // any byte: may open, close or stray
               add_byte(8'($urandom_range(0, 255)));
            end
         endcase
      end
   endtask

   initial begin
      for (int i = 0; i < DIR_ROWS; i++) stim_q.insert(stim_q.size(), DIRECTED[i]);
      build_random_stream();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Both channels, watchdog and end of run in one clocked process, so the
   // expectation queue never sees a push and a pop race within a time step.
   // ---------------------------------------------------------------------------------------
   byte_row_type cur_row;         // byte currently offered on req_*
   int           burst_left  = 0; // transfers left in the current sender burst
   int           gap_left    = 0; // idle cycles before the next burst
   logic [15:0]  stall_mask  = 16'hFFFF;
   logic [5:0]   stall_step  = '0;
   int           idle_cycles = 0;
   int           drain_count = 0;

   task automatic new_burst();
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                : $urandom_range(1, 16);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
   endtask

   always @(posedge clock) begin : bus_side
      logic moved;
      logic sending;
      moved   = 1'b0;
      sending = 1'b0;
      if (reset) begin
         req_valid   <= 1'b0;
         rsp_ready   <= 1'b0;
         seq_left    = '0;
         code_acc    = '0;
         idle_cycles = 0;
         drain_count = 0;
      end else begin
         // results first: a unit seen now can only stem from an earlier byte
         if (rsp_valid && rsp_ready) begin
            check_unit(rsp_code_unit, rsp_last_of_run);
            moved = 1'b1;
         end
         if (req_valid && req_ready) begin
            accept_row(cur_row);
            moved = 1'b1;
         end

         // sender: hold the byte until its transfer, then burst or gap
         if (req_valid && !req_ready) begin
            sending = 1'b1;
         end else if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (stim_q.size() != 0) begin
            cur_row = stim_q.pop_front();
            req_valid   <= 1'b1;
            req_in_byte <= cur_row.data;
            sending = 1'b1;
            if (burst_left > 1) burst_left--;
            else new_burst();
         end else begin
            req_valid <= 1'b0;
         end

         // receiver: 16-bit ready pattern walked by the step counter, redrawn when that 6-bit counter wraps
         if (stall_step == '0) begin
            case ($urandom_range(0, 3))
               0:       stall_mask = 16'hFFFF;
               1:       stall_mask = 16'($urandom);
               2:       stall_mask = 16'($urandom & $urandom);
               default: stall_mask = ~16'($urandom & $urandom);
            endcase
            stall_mask[0] = 1'b1; // never a pattern that blocks for good
         end
         rsp_ready  <= stall_mask[stall_step[3:0]];
         stall_step = stall_step + 6'd1;

         if (moved) idle_cycles = 0;
         else idle_cycles++;

         if (stim_q.size() == 0 && !sending && expected_units.size() == 0) drain_count++;
         else drain_count = 0;

         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end else if (drain_count >= DRAIN_CYCLES) begin
            if (fail_count == 0) begin
               $display("Test completed successfully");
            end else begin
               $display("Test completed with failures");
            end
            $finish;
         end
      end
   end

endmodule
